// ----- hw/rtl/kda_pkg.sv -----
// kda_pkg: shared types, widths and codes for the keyed degree accumulator
// used by kda_div and keyed_degree_accumulator, no dependencies

package kda_pkg;

  localparam int KEY_W      = 20;
  localparam int NODE_W     = 24;
  localparam int SUM_W      = 32;
  localparam int SMP_W      = 16;
  localparam int SLOT_W     = 8;
  localparam int STATUS_W   = 3;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;
  localparam int DIV_CNT_W  = $clog2(SUM_W);

  localparam int TABLE_DEPTH_DEF = 256;

  localparam logic OP_ACCUM = 1'b0;
  localparam logic OP_READ  = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_AVG_MODE  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_RUN_COUNT = 1'b1;

  localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};
  localparam logic [SMP_W-1:0] SMP_MAX = {SMP_W{1'b1}};

  typedef enum logic [STATUS_W-1:0] {
    ST_UPDATED  = 3'd0,
    ST_INSERTED = 3'd1,
    ST_FULL     = 3'd2,
    ST_READ_OK  = 3'd3,
    ST_EMPTY    = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_SEARCH,
    S_DIV_GO,
    S_DIV_WAIT,
    S_DONE
  } state_t;

  typedef struct packed {
    logic              operation;
    logic [KEY_W-1:0]  degree;
    logic [NODE_W-1:0] node_count;
    logic [SLOT_W-1:0] entry_index;
  } kda_in_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   slot;
    logic [KEY_W-1:0]    key_out;
    logic [SUM_W-1:0]    sum_out;
    logic [SMP_W-1:0]    samples_out;
    logic [SUM_W-1:0]    average_out;
  } kda_out_t;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [SUM_W-1:0] sum;
    logic [SMP_W-1:0] samples;
  } kda_entry_t;

endpackage

// ----- hw/rtl/kda_div.sv -----
// kda_div: restoring divider, 32-bit dividend by 16-bit divisor, one bit per cycle
// depends on kda_pkg

module kda_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [kda_pkg::SUM_W-1:0] dividend,
  input  logic [kda_pkg::SMP_W-1:0] divisor,
  output logic                      done,
  output logic [kda_pkg::SUM_W-1:0] quotient
);

  logic                          active_r;
  logic                          done_r;
  logic [kda_pkg::DIV_CNT_W-1:0] cnt_r;
  logic [kda_pkg::SUM_W-1:0]     quo_r;
  logic [kda_pkg::SMP_W-1:0]     rem_r;
  logic [kda_pkg::SMP_W-1:0]     dvs_r;

  logic [kda_pkg::SMP_W:0]       rem_sh;
  logic                          fits;
  logic [kda_pkg::SMP_W-1:0]     rem_nxt;

  // zero divisor always fits, so the quotient comes out all ones
  always_comb begin
    rem_sh  = {rem_r, quo_r[kda_pkg::SUM_W-1]};
    fits    = rem_sh >= {1'b0, dvs_r};
    rem_nxt = fits ? kda_pkg::SMP_W'(rem_sh - {1'b0, dvs_r})
                   : rem_sh[kda_pkg::SMP_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      done_r   <= 1'b0;
      cnt_r    <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        active_r <= 1'b1;
        cnt_r    <= '0;
      end else if (active_r) begin
        cnt_r <= cnt_r + kda_pkg::DIV_CNT_W'(1);
        if (cnt_r == {kda_pkg::DIV_CNT_W{1'b1}}) begin
          active_r <= 1'b0;
          done_r   <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (active_r) begin
      quo_r <= {quo_r[kda_pkg::SUM_W-2:0], fits};
      rem_r <= rem_nxt;
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

// ----- hw/rtl/keyed_degree_accumulator.sv -----
// keyed_degree_accumulator: keyed accumulation table with linear key search
// a read fetches the entry and divides, an empty index skips the fetch and the divide; an insert into
//   an empty table appends and divides, other accumulates scan then divide, a drop on a full table scans only
// throughput: one request at a time, the next taken once the result is loaded into the result register;
//   set by the one-entry-per-cycle memory scan and the bit-serial divider
// reset: synchronous active low, clears entry count and mode, sets run count to 1; table contents
//   stay undefined and only filled entries ever reach a result

module keyed_degree_accumulator #(
  parameter int TABLE_DEPTH = kda_pkg::TABLE_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // request channel
  input  logic                           in_valid,
  output logic                           in_stall,
  input  kda_pkg::kda_in_t               in_data,
  // result channel
  output logic                           out_valid,
  input  logic                           out_stall,
  output kda_pkg::kda_out_t              out_data,
  // configuration writes
  input  logic                           cfg_we,
  input  logic [kda_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [kda_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int IDX_W   = $clog2(TABLE_DEPTH);
  localparam int CNT_W   = $clog2(TABLE_DEPTH + 1);
  // common width for comparing the 8-bit request index with the fill count
  localparam int CMP_W   = (CNT_W > kda_pkg::SLOT_W) ? CNT_W : kda_pkg::SLOT_W;
  localparam int ENTRY_W = $bits(kda_pkg::kda_entry_t);

  // configuration registers
  logic                      mode_r;
  logic [kda_pkg::SMP_W-1:0] run_r;

  // control and request state
  kda_pkg::state_t      state_r, state_nxt;
  kda_pkg::kda_in_t     req_r, req_nxt;
  logic [IDX_W-1:0]     idx_r, idx_nxt;
  logic [CNT_W-1:0]     count_r, count_nxt;
  kda_pkg::kda_entry_t  ent_r, ent_nxt;
  kda_pkg::status_t     status_r, status_nxt;
  logic [kda_pkg::SLOT_W-1:0] slot_r, slot_nxt;
  logic [kda_pkg::SUM_W-1:0]  avg_r, avg_nxt;

  // result register
  kda_pkg::kda_out_t    out_r;
  logic                 out_valid_r;
  logic                 out_load;

  // table memory, one read and one write port
  logic [ENTRY_W-1:0]   mem [TABLE_DEPTH];
  logic                 mem_we;
  logic [IDX_W-1:0]     mem_waddr;
  kda_pkg::kda_entry_t  mem_wdata;
  logic [IDX_W-1:0]     mem_raddr;
  kda_pkg::kda_entry_t  rd_ent;
  logic [ENTRY_W-1:0]   rd_data_r;

  // divider hookup
  logic                      div_start;
  logic                      div_done;
  logic [kda_pkg::SUM_W-1:0] div_quo;
  logic [kda_pkg::SMP_W-1:0] div_dvs;

  // helpers
  logic                      in_acc;
  logic [CMP_W-1:0]          ridx_ext;
  logic [CMP_W-1:0]          count_ext;
  logic [CMP_W-1:0]          idx_ext;
  logic [CNT_W-1:0]          idx_next_cnt;
  logic [kda_pkg::SUM_W:0]   sum_wide;
  logic [kda_pkg::SUM_W-1:0] sum_upd;
  logic [kda_pkg::SMP_W-1:0] smp_upd;
  logic                      table_full;

  assign rd_ent  = kda_pkg::kda_entry_t'(rd_data_r);
  assign in_acc  = in_valid && !in_stall;
  assign in_stall = (state_r != kda_pkg::S_IDLE);

  always_comb begin
    ridx_ext     = CMP_W'(in_data.entry_index);
    count_ext    = CMP_W'(count_r);
    idx_ext      = CMP_W'(idx_r);
    idx_next_cnt = CNT_W'(idx_r) + CNT_W'(1);
    table_full   = (count_r == CNT_W'(TABLE_DEPTH));
    // saturating update of the entry that matched
    sum_wide     = {1'b0, rd_ent.sum} + (kda_pkg::SUM_W + 1)'(req_r.node_count);
    sum_upd      = sum_wide[kda_pkg::SUM_W] ? kda_pkg::SUM_MAX
                                            : sum_wide[kda_pkg::SUM_W-1:0];
    smp_upd      = (rd_ent.samples == kda_pkg::SMP_MAX) ? rd_ent.samples
                                                        : rd_ent.samples + kda_pkg::SMP_W'(1);
  end

  // next state and datapath control
  always_comb begin
    state_nxt  = state_r;
    req_nxt    = req_r;
    idx_nxt    = idx_r;
    count_nxt  = count_r;
    ent_nxt    = ent_r;
    status_nxt = status_r;
    slot_nxt   = slot_r;
    avg_nxt    = avg_r;
    mem_we     = 1'b0;
    mem_waddr  = count_r[IDX_W-1:0];
    mem_wdata  = ent_r;
    mem_raddr  = '0;
    div_start  = 1'b0;
    out_load   = 1'b0;

    case (state_r)
      kda_pkg::S_IDLE: begin
        if (in_acc) begin
          req_nxt = in_data;
          if (in_data.operation == kda_pkg::OP_READ) begin
            if (ridx_ext < count_ext) begin
              // only filled entries are fetched
              mem_raddr  = ridx_ext[IDX_W-1:0];
              slot_nxt   = in_data.entry_index;
              status_nxt = kda_pkg::ST_READ_OK;
              state_nxt  = kda_pkg::S_READ;
            end else begin
              slot_nxt   = in_data.entry_index;
              status_nxt = kda_pkg::ST_EMPTY;
              ent_nxt    = '0;
              avg_nxt    = '0;
              state_nxt  = kda_pkg::S_DONE;
            end
          end else if (count_r == '0) begin
            // empty table, append straight away
            mem_we     = 1'b1;
            mem_wdata  = '{key: in_data.degree,
                           sum: kda_pkg::SUM_W'(in_data.node_count),
                           samples: kda_pkg::SMP_W'(1)};
            ent_nxt    = mem_wdata;
            slot_nxt   = '0;
            count_nxt  = count_r + CNT_W'(1);
            status_nxt = kda_pkg::ST_INSERTED;
            state_nxt  = kda_pkg::S_DIV_GO;
          end else begin
            mem_raddr = '0;
            idx_nxt   = '0;
            state_nxt = kda_pkg::S_SEARCH;
          end
        end
      end

      kda_pkg::S_READ: begin
        ent_nxt   = rd_ent;
        state_nxt = kda_pkg::S_DIV_GO;
      end

      // rd_ent holds the entry at idx_r; the next entry is fetched meanwhile
      kda_pkg::S_SEARCH: begin
        mem_raddr = idx_next_cnt[IDX_W-1:0];
        if (rd_ent.key == req_r.degree) begin
          mem_we     = 1'b1;
          mem_waddr  = idx_r;
          mem_wdata  = '{key: rd_ent.key, sum: sum_upd, samples: smp_upd};
          ent_nxt    = mem_wdata;
          slot_nxt   = idx_ext[kda_pkg::SLOT_W-1:0];
          status_nxt = kda_pkg::ST_UPDATED;
          state_nxt  = kda_pkg::S_DIV_GO;
        end else if (idx_next_cnt < count_r) begin
          idx_nxt = idx_next_cnt[IDX_W-1:0];
        end else if (table_full) begin
          ent_nxt    = '0;
          avg_nxt    = '0;
          slot_nxt   = '0;
          status_nxt = kda_pkg::ST_FULL;
          state_nxt  = kda_pkg::S_DONE;
        end else begin
          // miss, append at the fill count
          mem_we     = 1'b1;
          mem_waddr  = count_r[IDX_W-1:0];
          mem_wdata  = '{key: req_r.degree,
                         sum: kda_pkg::SUM_W'(req_r.node_count),
                         samples: kda_pkg::SMP_W'(1)};
          ent_nxt    = mem_wdata;
          slot_nxt   = count_ext[kda_pkg::SLOT_W-1:0];
          count_nxt  = count_r + CNT_W'(1);
          status_nxt = kda_pkg::ST_INSERTED;
          state_nxt  = kda_pkg::S_DIV_GO;
        end
      end

      kda_pkg::S_DIV_GO: begin
        div_start = 1'b1;
        state_nxt = kda_pkg::S_DIV_WAIT;
      end

      kda_pkg::S_DIV_WAIT: begin
        if (div_done) begin
          avg_nxt   = div_quo;
          state_nxt = kda_pkg::S_DONE;
        end
      end

      kda_pkg::S_DONE: begin
        // hand over once the result register is free or draining
        if (!out_valid_r || !out_stall) begin
          out_load  = 1'b1;
          state_nxt = kda_pkg::S_IDLE;
        end
      end

      default: begin
        state_nxt = kda_pkg::S_IDLE;
      end
    endcase
  end

  // divisor: run count or the entry's own sample count
  assign div_dvs = mode_r ? run_r : ent_r.samples;

  kda_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (ent_r.sum),
    .divisor  (div_dvs),
    .done     (div_done),
    .quotient (div_quo)
  );

  // table memory
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= mem[mem_raddr];
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= kda_pkg::S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      mode_r      <= 1'b0;
      run_r       <= kda_pkg::SMP_W'(1);
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_we) begin
        case (cfg_index)
          kda_pkg::CFG_AVG_MODE:  mode_r <= cfg_data[0];
          kda_pkg::CFG_RUN_COUNT: run_r  <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    req_r    <= req_nxt;
    idx_r    <= idx_nxt;
    ent_r    <= ent_nxt;
    status_r <= status_nxt;
    slot_r   <= slot_nxt;
    avg_r    <= avg_nxt;
    if (out_load) begin
      out_r <= '{status:      status_r,
                 slot:        slot_r,
                 key_out:     ent_r.key,
                 sum_out:     ent_r.sum,
                 samples_out: ent_r.samples,
                 average_out: avg_r};
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // fill count never passes the table depth
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(TABLE_DEPTH))
    else $error("entry count beyond table depth");

  // table writes only while deciding an accumulate request
  a_write_state: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (state_r == kda_pkg::S_IDLE || state_r == kda_pkg::S_SEARCH))
    else $error("table write outside search");

  // an accepted request always leaves idle
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> state_r != kda_pkg::S_IDLE)
    else $error("request accepted but block stayed idle");

  // divider finishes only while being waited on
  a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> state_r == kda_pkg::S_DIV_WAIT)
    else $error("divider result with nobody waiting");

endmodule
